// ===== rtl/core/dlpg_pkg.sv =====
// dlpg_pkg: shared types and constants for the dda line pixel generator
// no dependencies; imported by every module of the block
package dlpg_pkg;

    localparam int SCREEN_H_BITS = 13;
    localparam logic [SCREEN_H_BITS-1:0] SCREEN_H_RESET = 13'd480;
    localparam int COLOUR_BITS = 32;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_STEP  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LINE
    } state_t;

    typedef struct packed {
        logic load_line;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic line_ok;
        logic fin;
        logic div_busy;
    } dp_status_t;

endpackage

// ===== rtl/core/dlpg_div.sv =====
// dlpg_div: restoring divider, one quotient bit per cycle, msb first
// depends on dlpg_pkg; used by dlpg_datapath for the slope
module dlpg_div #(
    parameter int W   = 13,
    parameter int Q_W = 17
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   num,
    input  logic [W-1:0]   den,
    output logic           busy,
    output logic [Q_W-1:0] quot
);
    import dlpg_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     den_reg;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic             ge;
    logic [W:0]       diff;

    always_comb begin
        ge        = rem_reg >= {1'b0, den_reg};
        diff      = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = {diff[W-1:0], 1'b0};
        quot_next = {quot_reg[Q_W-2:0], ge};
        cnt_next  = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(Q_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = quot_reg;

endmodule

// ===== rtl/core/dlpg_datapath.sv =====
// dlpg_datapath: line setup, slope divider, accumulator and output register
// depends on dlpg_pkg and dlpg_div; driven by dlpg_ctrl
module dlpg_datapath #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 13
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dlpg_pkg::SCREEN_H_BITS-1:0]  cfg_wr_data,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic [dlpg_pkg::COLOUR_BITS-1:0]    colour,
    input  dlpg_pkg::ctrl_cmd_t                 cmd,
    output dlpg_pkg::dp_status_t                status,
    output logic signed [COORD_BITS-1:0]        pixel_x,
    output logic signed [COORD_BITS:0]          pixel_row,
    output logic [dlpg_pkg::COLOUR_BITS-1:0]    pixel_colour,
    output logic                                pixel_last
);
    import dlpg_pkg::*;

    localparam int ACC_W   = COORD_BITS + FRAC_BITS + 1;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int SLOPE_W = FRAC_BITS + 2;
    localparam int ROW_W   = COORD_BITS + 1;
    localparam int CALC_W  = (ROW_W > SCREEN_H_BITS) ? ROW_W : SCREEN_H_BITS;

    logic [SCREEN_H_BITS-1:0]     screen_h_reg;
    logic                         major_x_reg;
    logic signed [COORD_BITS-1:0] major_pos_reg;
    logic signed [COORD_BITS-1:0] major_end_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic                         neg_reg;
    logic [COLOUR_BITS-1:0]       colour_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [ROW_W-1:0]      out_row_reg;
    logic [COLOUR_BITS-1:0]       out_colour_reg;
    logic                         out_last_reg;

    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0]        adx, ady, num, den;
    logic                         major_x, swap;
    logic signed [COORD_BITS-1:0] maj0, maj1, min0;
    logic signed [ACC_W-1:0]      acc_load, rnd;
    logic [Q_W-1:0]               quot;
    logic                         div_busy;
    logic signed [SLOPE_W-1:0]    slope_mag, slope;
    logic signed [COORD_BITS-1:0] minor, px, py;
    logic [CALC_W-1:0]            row_full;
    logic                         fin;

    // line setup from the start transfer
    always_comb begin
        dx       = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy       = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        adx      = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady      = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        major_x  = adx > ady;
        swap     = major_x ? dx[COORD_BITS] : dy[COORD_BITS];
        maj0     = major_x ? (swap ? end_x : start_x) : (swap ? end_y : start_y);
        maj1     = major_x ? (swap ? start_x : end_x) : (swap ? start_y : end_y);
        min0     = major_x ? (swap ? end_y : start_y) : (swap ? end_x : start_x);
        num      = major_x ? ady : adx;
        den      = major_x ? adx : ady;
        acc_load = ACC_W'(min0) <<< FRAC_BITS;
    end

    dlpg_div #(
        .W   (COORD_BITS),
        .Q_W (Q_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load_line),
        .num     (num),
        .den     (den),
        .busy    (div_busy),
        .quot    (quot)
    );

    // pixel of the current step
    always_comb begin
        slope_mag = {1'b0, quot};
        slope     = neg_reg ? -slope_mag : slope_mag;
        rnd       = acc_reg + (ACC_W'(1) << (FRAC_BITS - 1));
        minor     = rnd[FRAC_BITS +: COORD_BITS];
        px        = major_x_reg ? major_pos_reg : minor;
        py        = major_x_reg ? minor : major_pos_reg;
        row_full  = CALC_W'(screen_h_reg) - CALC_W'(1) - CALC_W'(py);
        fin       = major_pos_reg >= major_end_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_h_reg <= SCREEN_H_RESET;
        end else if (cfg_wr_en) begin
            screen_h_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_line) begin
            major_x_reg   <= major_x;
            major_pos_reg <= maj0;
            major_end_reg <= maj1;
            acc_reg       <= acc_load;
            neg_reg       <= dx[COORD_BITS] ^ dy[COORD_BITS];
            colour_reg    <= colour;
        end else if (cmd.emit && !fin) begin
            major_pos_reg <= major_pos_reg + COORD_BITS'(1);
            acc_reg       <= acc_reg + ACC_W'(slope);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_x_reg      <= px;
            out_row_reg    <= row_full[ROW_W-1:0];
            out_colour_reg <= colour_reg;
            out_last_reg   <= fin;
        end
    end

    assign status.line_ok  = major_x || (dy != '0);
    assign status.fin      = fin;
    assign status.div_busy = div_busy;

    assign pixel_x      = out_x_reg;
    assign pixel_row    = out_row_reg;
    assign pixel_colour = out_colour_reg;
    assign pixel_last   = out_last_reg;

endmodule

// ===== rtl/core/dlpg_ctrl.sv =====
// dlpg_ctrl: handshake control and line sequencing state machine
// depends on dlpg_pkg; commands dlpg_datapath
module dlpg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_mode,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dlpg_pkg::dp_status_t status,
    output dlpg_pkg::ctrl_cmd_t  cmd
);
    import dlpg_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free, in_ready, accept, is_start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        out_free       = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg && !m_tready;
        in_ready       = (state_reg != ST_DIV) && out_free;
        accept         = s_tvalid && in_ready;
        is_start       = mode_t'(s_mode) == MODE_START;
        case (state_reg)
            ST_IDLE, ST_LINE: begin
                if (accept && is_start) begin
                    cmd.load_line = 1'b1;
                    state_next    = status.line_ok ? ST_DIV : ST_IDLE;
                end else if (accept && state_reg == ST_LINE) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = status.fin ? ST_IDLE : ST_LINE;
                end
            end
            ST_DIV: begin
                if (!status.div_busy && out_free) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = status.fin ? ST_IDLE : ST_LINE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;

`ifndef SYNTH
    a_no_take_while_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> !s_tready)
        else $error("input taken during slope division");

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted pixel not presented");

    a_emit_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && state_reg == ST_DIV) |-> !status.div_busy && !cmd.load_line)
        else $error("first pixel emitted before slope ready");

    a_start_runs_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_line && status.line_ok) |=> status.div_busy && state_reg == ST_DIV)
        else $error("line start did not launch divider");
`endif

endmodule

// ===== rtl/core/dda_line_pixel_generator.sv =====
// dda line pixel generator top level: start transfer sets up a line, step transfers walk it
// a start transfer of a nonzero-length line runs the serial slope divide, then its first pixel goes out on m_axis
// throughput: step transfers are taken one per cycle while m_axis has room, each pixel registered in the cycle after
// a start transfer holds the input while the divider runs
// reset: aresetn synchronous active low, clears control and sets screen_height to 480
module dda_line_pixel_generator #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 13,
    localparam int IN_TW     = (((4 * COORD_BITS + dlpg_pkg::COLOUR_BITS) + 7) / 8) * 8,
    localparam int OUT_TW    = (((2 * COORD_BITS + 1 + dlpg_pkg::COLOUR_BITS) + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dlpg_pkg::SCREEN_H_BITS-1:0] cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_x, start_y, end_x, end_y, colour
    input  logic [IN_TW-1:0]                   s_axis_tdata,
    // mode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_x, pixel_row, pixel_colour
    output logic [OUT_TW-1:0]                  m_axis_tdata,
    output logic                               m_axis_tlast
);
    import dlpg_pkg::*;

    localparam int C = COORD_BITS;

    ctrl_cmd_t            cmd;
    dp_status_t           status;
    logic signed [C-1:0]  pixel_x;
    logic signed [C:0]    pixel_row;
    logic [COLOUR_BITS-1:0] pixel_colour;

    dlpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_mode   (s_axis_tuser),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dlpg_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .start_x      (s_axis_tdata[0 +: C]),
        .start_y      (s_axis_tdata[C +: C]),
        .end_x        (s_axis_tdata[2*C +: C]),
        .end_y        (s_axis_tdata[3*C +: C]),
        .colour       (s_axis_tdata[4*C +: COLOUR_BITS]),
        .cmd          (cmd),
        .status       (status),
        .pixel_x      (pixel_x),
        .pixel_row    (pixel_row),
        .pixel_colour (pixel_colour),
        .pixel_last   (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TW'({pixel_colour, pixel_row, pixel_x});

endmodule
